// ----- sv/fmwe_pkg.sv -----
// Shared types, codes and tables for the FM register write encoder.
package fmwe_pkg;

    typedef enum logic [3:0] {
        CMD_INIT     = 4'd0,
        CMD_DT_ML    = 4'd1,
        CMD_TL       = 4'd2,
        CMD_KS_AR    = 4'd3,
        CMD_AM_DR    = 4'd4,
        CMD_SR       = 4'd5,
        CMD_SL_RR    = 4'd6,
        CMD_SSGEG    = 4'd7,
        CMD_FNUM     = 4'd8,
        CMD_FB_CN    = 4'd9,
        CMD_PAN      = 4'd10,
        CMD_KEY      = 4'd11
    } cmd_t;

    localparam logic [1:0] CHIP_FIRST  = 2'd0;
    localparam logic [1:0] CHIP_SECOND = 2'd1;
    localparam logic [1:0] CHIP_BOTH   = 2'd2;

    localparam logic [7:0] ADDR_LFO_SETUP = 8'h22 - 8'h02;
    localparam logic [7:0] DATA_LFO_SETUP = 8'h02;
    localparam logic [7:0] ADDR_MODE      = 8'h29;
    localparam logic [7:0] DATA_MODE      = 8'h80;
    localparam logic [7:0] ADDR_KEY       = 8'h28;
    localparam logic [7:0] ADDR_DT_ML     = 8'h30;
    localparam logic [7:0] ADDR_TL        = 8'h40;
    localparam logic [7:0] ADDR_KS_AR     = 8'h50;
    localparam logic [7:0] ADDR_AM_DR     = 8'h60;
    localparam logic [7:0] ADDR_SR        = 8'h70;
    localparam logic [7:0] ADDR_SL_RR     = 8'h80;
    localparam logic [7:0] ADDR_SSGEG     = 8'h90;
    localparam logic [7:0] ADDR_FNUM_LO   = 8'hA0;
    localparam logic [7:0] ADDR_FNUM_HI   = 8'hA4;
    localparam logic [7:0] ADDR_FB_CN     = 8'hB0;
    localparam logic [7:0] ADDR_PAN       = 8'hB4;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  channel;
        logic [3:0]  operator;
        logic [10:0] value_a;
        logic [3:0]  value_b;
        logic [1:0]  pan_bits;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0] chip_select;
        logic       port_select;
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       last_write;
    } wr_word_t;

    typedef struct packed {
        logic [1:0] count;
        wr_word_t   first;
        wr_word_t   second;
    } wr_pair_t;

    typedef struct packed {
        logic       ok;
        logic       chip;
        logic       port;
        logic [1:0] pos;
    } chan_loc_t;

    function automatic logic [3:0] slot_offset(input logic [1:0] slot);
        logic [3:0] r;
        case (slot)
            2'd0:    r = 4'd0;
            2'd1:    r = 4'd8;
            2'd2:    r = 4'd4;
            default: r = 4'd12;
        endcase
        return r;
    endfunction

    function automatic chan_loc_t chan_loc(input logic [3:0] ch);
        chan_loc_t r;
        r = '0;
        case (ch)
            4'd0:    r = '{1'b1, 1'b0, 1'b0, 2'd0};
            4'd1:    r = '{1'b1, 1'b0, 1'b0, 2'd1};
            4'd2:    r = '{1'b1, 1'b0, 1'b0, 2'd2};
            4'd3:    r = '{1'b1, 1'b0, 1'b1, 2'd0};
            4'd4:    r = '{1'b1, 1'b0, 1'b1, 2'd1};
            4'd5:    r = '{1'b1, 1'b0, 1'b1, 2'd2};
            4'd6:    r = '{1'b1, 1'b1, 1'b0, 2'd0};
            4'd7:    r = '{1'b1, 1'b1, 1'b0, 2'd1};
            4'd8:    r = '{1'b1, 1'b1, 1'b0, 2'd2};
            4'd9:    r = '{1'b1, 1'b1, 1'b1, 2'd0};
            4'd10:   r = '{1'b1, 1'b1, 1'b1, 2'd1};
            4'd11:   r = '{1'b1, 1'b1, 1'b1, 2'd2};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/fmwe_cmd_if.sv -----
// Command channel: valid/ready handshake with the command fields.
interface fmwe_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [3:0]  channel;
    logic [3:0]  operator;
    logic [10:0] value_a;
    logic [3:0]  value_b;
    logic [1:0]  pan_bits;

    modport source (
        output valid, command, channel, operator, value_a, value_b, pan_bits,
        input  ready
    );
    modport sink (
        input  valid, command, channel, operator, value_a, value_b, pan_bits,
        output ready
    );
endinterface

// ----- sv/fmwe_wr_if.sv -----
// Register write channel: valid/ready handshake with one chip-register write.
interface fmwe_wr_if;
    logic       valid;
    logic       ready;
    logic [1:0] chip_select;
    logic       port_select;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       last_write;

    modport source (
        output valid, chip_select, port_select, reg_address, reg_data, last_write,
        input  ready
    );
    modport sink (
        input  valid, chip_select, port_select, reg_address, reg_data, last_write,
        output ready
    );
endinterface

// ----- sv/fmwe_decode.sv -----
// Command decoder: maps one command word to up to two register writes.
module fmwe_decode (
    input  fmwe_pkg::cmd_word_t word,
    output fmwe_pkg::wr_pair_t  pair
);
    import fmwe_pkg::*;

    chan_loc_t  loc;
    logic [3:0] oaddr;
    logic [7:0] op_addr;
    logic [7:0] pos_addr;
    wr_word_t   w0;
    wr_word_t   w1;
    logic [1:0] count;

    assign loc      = chan_loc(word.channel);
    assign oaddr    = slot_offset(word.operator[1:0]) + {2'b00, loc.pos};
    assign op_addr  = {4'b0000, oaddr};
    assign pos_addr = {6'b000000, loc.pos};

    always_comb
    begin
        w0             = '0;
        w1             = '0;
        count          = 2'd0;
        w0.chip_select = loc.chip ? CHIP_SECOND : CHIP_FIRST;
        w0.port_select = loc.port;
        w0.last_write  = 1'b1;
        w1.chip_select = w0.chip_select;
        w1.port_select = loc.port;
        w1.last_write  = 1'b1;
        if (word.command == CMD_INIT)
        begin
            count          = 2'd2;
            w0.chip_select = CHIP_BOTH;
            w0.port_select = 1'b0;
            w0.reg_address = ADDR_LFO_SETUP;
            w0.reg_data    = DATA_LFO_SETUP;
            w0.last_write  = 1'b0;
            w1.chip_select = CHIP_BOTH;
            w1.port_select = 1'b0;
            w1.reg_address = ADDR_MODE;
            w1.reg_data    = DATA_MODE;
        end
        else if (loc.ok)
        begin
            count = 2'd1;
            case (word.command)
                CMD_DT_ML:
                begin
                    w0.reg_address = ADDR_DT_ML + op_addr;
                    w0.reg_data    = {1'b0, word.value_b[2:0], word.value_a[3:0]};
                end
                CMD_TL:
                begin
                    w0.reg_address = ADDR_TL + op_addr;
                    w0.reg_data    = {1'b0, word.value_a[6:0]};
                end
                CMD_KS_AR:
                begin
                    w0.reg_address = ADDR_KS_AR + op_addr;
                    w0.reg_data    = {word.value_b[1:0], 1'b0, word.value_a[4:0]};
                end
                CMD_AM_DR:
                begin
                    w0.reg_address = ADDR_AM_DR + op_addr;
                    w0.reg_data    = {word.value_b[0], 2'b00, word.value_a[4:0]};
                end
                CMD_SR:
                begin
                    w0.reg_address = ADDR_SR + op_addr;
                    w0.reg_data    = {3'b000, word.value_a[4:0]};
                end
                CMD_SL_RR:
                begin
                    w0.reg_address = ADDR_SL_RR + op_addr;
                    w0.reg_data    = {word.value_b, word.value_a[3:0]};
                end
                CMD_SSGEG:
                begin
                    w0.reg_address = ADDR_SSGEG + op_addr;
                    w0.reg_data    = {4'b0000, word.value_a[3:0]};
                end
                CMD_FNUM:
                begin
                    count          = 2'd2;
                    w0.reg_address = ADDR_FNUM_HI + pos_addr;
                    w0.reg_data    = {2'b00, word.value_b[2:0], word.value_a[10:8]};
                    w0.last_write  = 1'b0;
                    w1.reg_address = ADDR_FNUM_LO + pos_addr;
                    w1.reg_data    = word.value_a[7:0];
                end
                CMD_FB_CN:
                begin
                    w0.reg_address = ADDR_FB_CN + pos_addr;
                    w0.reg_data    = {2'b00, word.value_b[2:0], word.value_a[2:0]};
                end
                CMD_PAN:
                begin
                    w0.reg_address = ADDR_PAN + pos_addr;
                    w0.reg_data    = {word.pan_bits, word.value_b[1:0], 1'b0,
                                      word.value_a[2:0]};
                end
                CMD_KEY:
                begin
                    w0.port_select = 1'b0;
                    w0.reg_address = ADDR_KEY;
                    w0.reg_data    = {word.operator, 1'b0, loc.port, loc.pos};
                end
                default:
                begin
                    count = 2'd0;
                end
            endcase
        end
    end

    assign pair.count  = count;
    assign pair.first  = w0;
    assign pair.second = w1;

endmodule

// ----- sv/fmwe_emit.sv -----
// Write emitter: output register plus one pending write for two-write commands.
module fmwe_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    input  fmwe_pkg::wr_pair_t pair,
    output logic               pair_ready,
    fmwe_wr_if.source          wr
);
    import fmwe_pkg::*;

    logic     out_valid_reg;
    logic     out_valid_next;
    wr_word_t out_word_reg;
    wr_word_t out_word_next;
    logic     pend_valid_reg;
    logic     pend_valid_next;
    wr_word_t pend_word_reg;
    wr_word_t pend_word_next;
    logic     out_free;
    logic     take_pair;

    assign out_free   = !out_valid_reg || wr.ready;
    assign pair_ready = !pend_valid_reg && out_free;
    assign take_pair  = pair_valid && pair_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (take_pair)
        begin
            if (pair.count != 2'd0)
            begin
                out_valid_next = 1'b1;
                out_word_next  = pair.first;
            end
            if (pair.count == 2'd2)
            begin
                pend_valid_next = 1'b1;
                pend_word_next  = pair.second;
            end
        end
        else if (out_free && pend_valid_reg)
        begin
            // advance the held second write
            out_valid_next  = 1'b1;
            out_word_next   = pend_word_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        pend_word_reg <= pend_word_next;
    end

    assign wr.valid       = out_valid_reg;
    assign wr.chip_select = out_word_reg.chip_select;
    assign wr.port_select = out_word_reg.port_select;
    assign wr.reg_address = out_word_reg.reg_address;
    assign wr.reg_data    = out_word_reg.reg_data;
    assign wr.last_write  = out_word_reg.last_write;

endmodule

// ----- sv/fm_synth_register_write_encoder_top.sv -----
// A taken command is registered, decoded, and its first write held in the output register.
// Throughput: one command per cycle when each gives one write and the port is not stalled;
// init and frequency commands give two writes; the next waits on the held second write.
// Commands with no write are taken at one per cycle while the write port is not stalled.
// Reset: rst_n clears the input, output and pending valid flags; nothing else is held.
module fm_synth_register_write_encoder_top (
    input  logic      clk,
    input  logic      rst_n,
    fmwe_cmd_if.sink  cmd,
    fmwe_wr_if.source wr
);
    import fmwe_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    cmd_word_t in_word_reg;
    cmd_word_t in_word_next;
    wr_pair_t  pair;
    logic      pair_ready;
    logic      take_cmd;

    assign cmd.ready = !in_valid_reg || pair_ready;
    assign take_cmd  = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (pair_ready)
        begin
            in_valid_next = 1'b0;
        end
        if (take_cmd)
        begin
            in_valid_next         = 1'b1;
            in_word_next.command  = cmd.command;
            in_word_next.channel  = cmd.channel;
            in_word_next.operator = cmd.operator;
            in_word_next.value_a  = cmd.value_a;
            in_word_next.value_b  = cmd.value_b;
            in_word_next.pan_bits = cmd.pan_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg <= in_word_next;
    end

    fmwe_decode u_decode (
        .word (in_word_reg),
        .pair (pair)
    );

    fmwe_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (in_valid_reg),
        .pair       (pair),
        .pair_ready (pair_ready),
        .wr         (wr)
    );

endmodule
